@@ src/oahs_pkg.sv @@
// Shared types, constants and the control store of the open-addressing hash set.
package oahs_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 6;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int BIT_CW = 1;

    localparam logic REG_PROBE_MODE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_TOMB  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_INIT,
        S_RD,
        S_EVAL,
        S_FIN
    } t_step;

    typedef enum logic [2:0] {
        A_CLR,
        A_IDLE,
        A_DIV,
        A_INIT,
        A_RD,
        A_EVAL,
        A_FIN
    } t_act;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_CLR_LAST,
        C_IN_VALID,
        C_DIV_LAST,
        C_NOP_OP,
        C_STOP,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uword;

    typedef struct packed {
        logic clr_last;
        logic in_valid;
        logic div_last;
        logic nop_op;
        logic stop;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_CLR:   w = '{act: A_CLR,  cond: C_CLR_LAST, jmp: S_IDLE, nxt: S_CLR};
            S_IDLE:  w = '{act: A_IDLE, cond: C_IN_VALID, jmp: S_DIV,  nxt: S_IDLE};
            S_DIV:   w = '{act: A_DIV,  cond: C_DIV_LAST, jmp: S_INIT, nxt: S_DIV};
            S_INIT:  w = '{act: A_INIT, cond: C_NOP_OP,   jmp: S_FIN,  nxt: S_RD};
            S_RD:    w = '{act: A_RD,   cond: C_ALWAYS,   jmp: S_EVAL, nxt: S_EVAL};
            S_EVAL:  w = '{act: A_EVAL, cond: C_STOP,     jmp: S_FIN,  nxt: S_RD};
            S_FIN:   w = '{act: A_FIN,  cond: C_OUT_FREE, jmp: S_IDLE, nxt: S_FIN};
            default: w = '{act: A_IDLE, cond: C_ALWAYS,   jmp: S_IDLE, nxt: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/oahs_in_if.sv @@
// Request channel carrying an opcode and a key.
interface oahs_in_if;
    import oahs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink (input valid, input opcode, input key, output ready);
endinterface

@@ src/oahs_out_if.sv @@
// Response channel carrying the found flag, the slot and the full flag.
interface oahs_out_if;
    import oahs_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              full_res;

    modport source (output valid, output found, output slot, output full_res, input ready);
    modport sink (input valid, input found, input slot, input full_res, output ready);
endinterface

@@ src/oahs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module oahs_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/oahs_useq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module oahs_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  oahs_pkg::t_stat  i_stat,
    output oahs_pkg::t_uword o_uw
);
    import oahs_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uw = ucode(r_step);
        unique case (uw.cond)
            C_ALWAYS:   take = 1'b1;
            C_CLR_LAST: take = i_stat.clr_last;
            C_IN_VALID: take = i_stat.in_valid;
            C_DIV_LAST: take = i_stat.div_last;
            C_NOP_OP:   take = i_stat.nop_op;
            C_STOP:     take = i_stat.stop;
            C_OUT_FREE: take = i_stat.out_free;
            default:    take = 1'b1;
        endcase
        n_step = take ? uw.jmp : uw.nxt;
    end

    assign o_uw = uw;
endmodule

@@ src/oahs_dp.sv @@
// Datapath: home slot divider, probe address generator, slot memory and result register.
module oahs_dp #(
    parameter int TABLE_SIZE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  oahs_pkg::t_uword i_uw,
    input  logic             i_probe_mode,
    output oahs_pkg::t_stat  o_stat,
    oahs_in_if.sink          i_in,
    oahs_out_if.source       o_out
);
    import oahs_pkg::*;

    localparam int           IW    = $clog2(TABLE_SIZE);
    localparam int           MW    = ST_W + KEY_W;
    localparam logic [IW:0]  N_EXT = (IW + 1)'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);
    localparam logic [2*KEY_W-1:0] RECIP = (2*KEY_W)'((64'd1 << KEY_W) / TABLE_SIZE);

    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_key;
    logic [KEY_W-1:0]  r_mag;
    logic [KEY_W-1:0]  r_quo;
    logic [BIT_CW-1:0] r_bcnt;
    logic [IW:0]       r_rem;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_d;
    logic              r_hit;
    logic              r_have_free;
    logic [IW-1:0]     r_free_idx;
    logic              r_out_valid;
    logic              r_found;
    logic [SLOT_W-1:0] r_slot;
    logic              r_full;

    logic [KEY_W-1:0]   key_in;
    logic [KEY_W-1:0]   mag_in;
    logic [2*KEY_W-1:0] prod;
    logic [IW:0]        qn;
    logic [IW:0]        rem_lo;
    logic [IW-1:0]      stp;
    logic [IW:0]        idx_sum;
    logic [IW-1:0]      idx_nx;
    logic [IW:0]        d_sum;
    logic [IW-1:0]      d_nx;
    logic [MW-1:0]      rdata;
    t_status            rd_st;
    logic               is_empty;
    logic               is_tomb;
    logic               is_match;
    logic               last;
    logic               stop;
    logic               out_free;
    logic               accept;
    logic               fin_fire;
    logic               op_ins;
    logic               op_rem;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [MW-1:0]      ram_wdata;
    logic               ram_re;

    assign key_in = i_in.key;
    assign mag_in = key_in[KEY_W-1] ? (~key_in + KEY_W'(1)) : key_in;

    // The quotient estimate is at most one short, so the low bits of the
    // difference hold a value below twice the table size.
    assign prod   = {{KEY_W{1'b0}}, r_mag} * RECIP;
    assign qn     = r_quo[IW:0] * N_EXT;
    assign rem_lo = r_mag[IW:0] - qn;

    assign stp     = i_probe_mode ? r_d : IW'(1);
    assign idx_sum = {1'b0, r_idx} + {1'b0, stp};
    assign idx_nx  = (idx_sum >= N_EXT) ? IW'(idx_sum - N_EXT) : IW'(idx_sum);
    assign d_sum   = {1'b0, r_d} + (IW + 1)'(2);
    assign d_nx    = (d_sum >= N_EXT) ? IW'(d_sum - N_EXT) : IW'(d_sum);

    assign rd_st    = t_status'(rdata[KEY_W +: ST_W]);
    assign is_empty = (rd_st == ST_EMPTY);
    assign is_tomb  = (rd_st == ST_TOMB);
    assign is_match = (rd_st == ST_USED) && (rdata[KEY_W-1:0] == r_key);
    assign last     = (r_i == LAST);
    assign stop     = is_empty || is_match || last;

    assign op_ins   = (r_op == OP_INSERT);
    assign op_rem   = (r_op == OP_REMOVE);
    assign out_free = !r_out_valid || o_out.ready;
    assign accept   = (i_uw.act == A_IDLE) && i_in.valid;
    assign fin_fire = (i_uw.act == A_FIN) && out_free;

    assign i_in.ready = (i_uw.act == A_IDLE);

    assign o_stat.clr_last = (r_idx == LAST);
    assign o_stat.in_valid = i_in.valid;
    assign o_stat.div_last = (r_bcnt == {BIT_CW{1'b1}});
    assign o_stat.nop_op   = !(op_ins || op_rem || (r_op == OP_SEARCH));
    assign o_stat.stop     = stop;
    assign o_stat.out_free = out_free;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {ST_EMPTY, r_key};
        ram_re    = (i_uw.act == A_RD);
        if (i_uw.act == A_CLR) begin
            ram_we = 1'b1;
        end else if (fin_fire) begin
            if (r_hit && op_rem) begin
                ram_we    = 1'b1;
                ram_wdata = {ST_TOMB, r_key};
            end else if (!r_hit && op_ins && r_have_free) begin
                ram_we    = 1'b1;
                ram_waddr = r_free_idx;
                ram_wdata = {ST_USED, r_key};
            end
        end
    end

    oahs_ram #(
        .WIDTH(MW),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_op   <= i_in.opcode;
                r_key  <= key_in;
                r_mag  <= mag_in;
                r_rem  <= '0;
                r_bcnt <= '0;
            end
            unique case (i_uw.act)
                A_CLR: begin
                    r_idx <= (r_idx == LAST) ? '0 : r_idx + IW'(1);
                end
                A_DIV: begin
                    if (r_bcnt == '0) begin
                        r_quo <= prod[2*KEY_W-1:KEY_W];
                    end else begin
                        r_rem <= rem_lo;
                    end
                    r_bcnt <= r_bcnt + BIT_CW'(1);
                end
                A_INIT: begin
                    r_idx       <= (r_rem >= N_EXT) ? IW'(r_rem - N_EXT) : IW'(r_rem);
                    r_i         <= '0;
                    r_d         <= IW'(1);
                    r_hit       <= 1'b0;
                    r_have_free <= 1'b0;
                end
                A_EVAL: begin
                    if ((is_empty || is_tomb) && !r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free_idx  <= r_idx;
                    end
                    if (is_match) begin
                        r_hit <= 1'b1;
                    end
                    if (!stop) begin
                        r_idx <= idx_nx;
                        r_d   <= d_nx;
                        r_i   <= r_i + IW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (fin_fire) begin
                r_out_valid <= 1'b1;
                r_found     <= r_hit;
                r_full      <= !r_hit && op_ins && !r_have_free;
                if (r_hit) begin
                    r_slot <= SLOT_W'(r_idx);
                end else if (op_ins && r_have_free) begin
                    r_slot <= SLOT_W'(r_free_idx);
                end else begin
                    r_slot <= '0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.found    = r_found;
    assign o_out.slot     = r_slot;
    assign o_out.full_res = r_full;
endmodule

@@ src/open_addressing_hash_set.sv @@
// Top level of the open-addressing hash set with its configuration register.
// The block keeps a table of TABLE_SIZE signed 32-bit keys and serves one insert, search or
// remove word at a time. After reset it marks every slot empty and takes no word meanwhile.
// Each word then finds its home slot by multiplying the key magnitude by the reciprocal of
// TABLE_SIZE and subtracting the product back, and probes from 1 to TABLE_SIZE slots; every
// probe reads the slot memory and then compares. An unused opcode skips the probes.
// A finished result waits in an output register while the next word is taken; a word stalls
// in its final step for as long as the previous result has not been taken.
// The probe mode register at byte address 0 selects linear (0) or
// quadratic (1) probing and should only be written while no word is in progress.
module open_addressing_hash_set #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    oahs_in_if.sink                       i_in,
    oahs_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [oahs_pkg::APB_AW-1:0]   paddr,
    input  logic [oahs_pkg::APB_DW-1:0]   pwdata,
    output logic [oahs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import oahs_pkg::*;

    logic   r_probe_mode;
    logic   cfg_sel;
    t_uword uw;
    t_stat  stat;

    assign cfg_sel = (paddr[2] == REG_PROBE_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_mode <= 1'b0;
        end else if (psel && penable && pwrite && cfg_sel) begin
            r_probe_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_sel ? {{(APB_DW - 1){1'b0}}, r_probe_mode} : '0;

    oahs_useq u_useq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_uw   (uw)
    );

    oahs_dp #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uw        (uw),
        .i_probe_mode(r_probe_mode),
        .o_stat      (stat),
        .i_in        (i_in),
        .o_out       (o_out)
    );
endmodule

@@ bench/open_addressing_hash_set_test.sv @@
// Self-checking testbench of the open-addressing hash set, directed table then random words.
module open_addressing_hash_set_test;
    import oahs_pkg::*;

    localparam int TBL         = 64;
    localparam int LIMIT       = 1_000_000;
    localparam int TAIL        = 200;
    localparam int HOLD_AT     = 350;
    localparam int HOLD_CYCLES = 1500;

    localparam logic [OP_W-1:0]   OP_NONE        = 2'd3;
    localparam logic              MODE_LINEAR    = 1'b0;
    localparam logic              MODE_QUADRATIC = 1'b1;
    localparam logic [APB_AW-1:0] MODE_ADDR      = APB_AW'(4 * int'(REG_PROBE_MODE));

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              full;
    } t_reply;

    typedef struct packed {
        logic             mode;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             typed;
        t_reply           want;
    } t_row;

    // Rows with typed set carry their own expected word; the rest rely on the table model.
    localparam t_row PLAN [27] = '{
        '{MODE_LINEAR, OP_SEARCH, 32'd5, 1'b1, '{1'b0, 6'd0, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'd5, 1'b1, '{1'b0, 6'd5, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'd5, 1'b1, '{1'b1, 6'd5, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'd69, 1'b1, '{1'b0, 6'd6, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, -32'sd5, 1'b1, '{1'b0, 6'd7, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 6'd63, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'h8000_0001, 1'b1, '{1'b0, 6'd0, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 6'd1, 1'b0}},
        '{MODE_LINEAR, OP_REMOVE, 32'd69, 1'b1, '{1'b1, 6'd6, 1'b0}},
        '{MODE_LINEAR, OP_SEARCH, -32'sd5, 1'b1, '{1'b1, 6'd7, 1'b0}},
        '{MODE_LINEAR, OP_INSERT, 32'd133, 1'b1, '{1'b0, 6'd6, 1'b0}},
        '{MODE_LINEAR, OP_REMOVE, -32'sd1, 1'b1, '{1'b0, 6'd0, 1'b0}},
        '{MODE_LINEAR, OP_NONE, 32'd5, 1'b1, '{1'b0, 6'd0, 1'b0}},
        '{MODE_LINEAR, OP_SEARCH, 32'h8000_0000, 1'b1, '{1'b1, 6'd1, 1'b0}},
        '{MODE_QUADRATIC, OP_INSERT, 32'd10, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, -32'sd74, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd138, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, -32'sd202, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd266, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd330, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, -32'sd394, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd458, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd522, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, -32'sd586, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd650, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, 32'd714, 1'b0, '0},
        '{MODE_QUADRATIC, OP_INSERT, -32'sd778, 1'b1, '{1'b0, 6'd0, 1'b1}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    oahs_in_if  req ();
    oahs_out_if rsp ();

    open_addressing_hash_set #(.TABLE_SIZE(TBL)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req),
        .o_out   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [KEY_W-1:0] slot_key [TBL];
    t_status          slot_state [TBL];
    logic             quad_probe;

    t_reply pending_replies [$];
    int     mismatches   = 0;
    int     words_sent   = 0;
    int     results_seen = 0;
    int     cycles       = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("open_addressing_hash_set_test NOT OK");
            $finish;
        end
    end

    function automatic t_reply apply_to_table(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] key);
        t_reply           r;
        logic [KEY_W-1:0] mag;
        int               home;
        int               idx;
        int               free_idx;
        int               hit_idx;
        bit               hit;
        bit               have_free;
        r         = '0;
        hit       = 1'b0;
        have_free = 1'b0;
        free_idx  = 0;
        hit_idx   = 0;
        mag       = key[KEY_W-1] ? -key : key;
        home      = int'(mag % KEY_W'(TBL));
        if (op == OP_NONE) return r;
        for (int i = 0; i < TBL; i++) begin
            idx = (home + (quad_probe ? i * i : i)) % TBL;
            if (slot_state[idx] == ST_EMPTY) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    free_idx  = idx;
                end
                break;
            end
            if (slot_state[idx] == ST_TOMB) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    free_idx  = idx;
                end
                continue;
            end
            if (slot_key[idx] == key) begin
                hit     = 1'b1;
                hit_idx = idx;
                break;
            end
        end
        if (hit) begin
            r.found = 1'b1;
            r.slot  = SLOT_W'(hit_idx);
            if (op == OP_REMOVE) slot_state[hit_idx] = ST_TOMB;
        end else if (op == OP_INSERT) begin
            if (have_free) begin
                slot_key[free_idx]   = key;
                slot_state[free_idx] = ST_USED;
                r.slot               = SLOT_W'(free_idx);
            end else begin
                r.full = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] draw_key(input int spread);
        logic [KEY_W-1:0] mag;
        mag = KEY_W'($urandom_range(0, 32'h01FF_FFFF)) * KEY_W'(TBL)
              + KEY_W'($urandom_range(0, spread - 1));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("cycle %0d: %s: got %0d, expected %0d", cycles, what, got, want);
    endtask

    task automatic check_reply();
        t_reply want;
        if (pending_replies.size() == 0) begin
            report_mismatch("word with nothing outstanding, slot", rsp.slot, 0);
            return;
        end
        want = pending_replies.pop_front();
        if (rsp.found !== want.found) report_mismatch("found", rsp.found, want.found);
        if (rsp.slot !== want.slot) report_mismatch("slot", rsp.slot, want.slot);
        if (rsp.full_res !== want.full) report_mismatch("full_res", rsp.full_res, want.full);
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic typed, input t_reply want);
        int     gap;
        t_reply model;
        gap = (words_sent % 64 < 16) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.key    <= key;
        do @(posedge i_clk); while (req.ready !== 1'b1);
        model = apply_to_table(op, key);
        pending_replies.push_back(typed ? want : model);
        words_sent++;
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_probe_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {{(APB_DW-1){1'b0}}, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        quad_probe = mode;
    endtask

    task automatic sweep_table();
        logic [KEY_W-1:0] live [$];
        foreach (slot_state[i]) if (slot_state[i] == ST_USED) live.push_back(slot_key[i]);
        foreach (live[j]) issue(OP_REMOVE, live[j], 1'b0, '0);
    endtask

    task automatic random_phase(input logic mode, input int count, input int pool_n,
                                input int spread);
        logic [KEY_W-1:0] pool [$];
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        int               pick;
        int               taken;
        settle();
        write_probe_mode(mode);
        pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
        repeat (pool_n) pool.push_back(draw_key(spread));
        taken = 0;
        while (taken < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) op = OP_INSERT;
            else if (pick < 70) op = OP_SEARCH;
            else if (pick < 93) op = OP_REMOVE;
            else op = OP_NONE;
            key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom())
                                               : pool[$urandom_range(0, pool.size() - 1)];
            issue(op, key, 1'b0, '0);
            if (op != OP_NONE) taken++;
        end
        sweep_table();
    endtask

    initial begin : drain
        int pause;
        rsp.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            pause = (results_seen % 64 < 16) ? 0 : $urandom_range(0, 5);
            if (pause > 0) begin
                rsp.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge i_clk); while (rsp.valid !== 1'b1);
            check_reply();
            results_seen++;
            if (results_seen == HOLD_AT) begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        i_rst_n    <= 1'b0;
        req.valid  <= 1'b0;
        req.opcode <= OP_INSERT;
        req.key    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        quad_probe = MODE_LINEAR;
        foreach (slot_state[i]) slot_state[i] = ST_EMPTY;
        foreach (slot_key[i]) slot_key[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(PLAN); r++) begin
            if (PLAN[r].mode != quad_probe) begin
                settle();
                write_probe_mode(PLAN[r].mode);
            end
            issue(PLAN[r].op, PLAN[r].key, PLAN[r].typed, PLAN[r].want);
        end
        sweep_table();

        random_phase(MODE_LINEAR, 160, 110, 64);
        random_phase(MODE_QUADRATIC, 160, 40, 8);
        random_phase(MODE_LINEAR, 160, 70, 4);
        random_phase(MODE_QUADRATIC, 160, 80, 64);

        settle();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("open_addressing_hash_set_test OK");
        end else begin
            $display("open_addressing_hash_set_test NOT OK");
        end
        $finish;
    end

endmodule
